// File: rtl/vnb_pkg.sv
package vnb_pkg;

	localparam int COORD_WIDTH  = 32;
	localparam int FRAC_BITS    = 30;
	localparam int UNIT_W       = FRAC_BITS + 2;
	localparam int PROD_W       = 2 * COORD_WIDTH;
	localparam int CROSS_W      = 2 * COORD_WIDTH + 1;
	localparam int BPROD_W      = 2 * UNIT_W;
	localparam int BCROSS_W     = 2 * UNIT_W + 1;
	localparam int NORM_W       = (CROSS_W > BCROSS_W) ? CROSS_W : BCROSS_W;
	localparam int SHIFT_STAGES = $clog2(NORM_W);
	localparam int SUM_W        = 2 * UNIT_W + 2;
	localparam int ROOT_W       = UNIT_W + 1;
	localparam int SQ_REM_W     = UNIT_W + 4;
	localparam int DIV_REM_W    = UNIT_W + 2;
	localparam int NORM_LAT     = SHIFT_STAGES + 2 * UNIT_W + 5;
	localparam int BACK_LAT     = 2 * NORM_LAT + 3;
	localparam int FIFO_DEPTH   = 4;
	localparam int FIFO_AW      = $clog2(FIFO_DEPTH);

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic signed [UNIT_W-1:0] unit_t;

	typedef enum logic [1:0] {
		ST_OK            = 2'd0,
		ST_ZERO_VEL      = 2'd1,
		ST_ZERO_NORMAL   = 2'd2,
		ST_ZERO_BINORMAL = 2'd3
	} status_t;

	typedef struct packed {
		coord_t pos_x;
		coord_t pos_y;
		coord_t pos_z;
		coord_t vel_x;
		coord_t vel_y;
		coord_t vel_z;
	} in_item_t;

	typedef struct packed {
		unit_t v_x;
		unit_t v_y;
		unit_t v_z;
		unit_t n_x;
		unit_t n_y;
		unit_t n_z;
		unit_t b_x;
		unit_t b_y;
		unit_t b_z;
		logic [1:0] status;
	} out_item_t;

	typedef logic [2:0][NORM_W-1:0] nvec_t;
	typedef logic [2:0][UNIT_W-1:0] uvec_t;

	typedef struct packed {
		logic [2:0][CROSS_W-1:0] rxv;
		logic [2:0][COORD_WIDTH-1:0] vel;
		logic vzero;
	} mid_item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

endpackage

// File: rtl/vnb_frame_basis_core.sv
// Velocity-normal-binormal basis from one position and one velocity vector. The block
// is fully pipelined and takes one transfer per clock unless the queue is full and
// the front stage holds an item; each item passes the front stage, which forms r x v,
// then waits in a four-entry queue, and passes the back stage, where each
// normalisation is a bit-per-stage square root followed by a bit-per-stage divide.
module vnb_frame_basis_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  vnb_pkg::in_item_t  item,
	output logic               result_valid,
	input  logic               result_ready,
	output vnb_pkg::out_item_t result
);
	import vnb_pkg::*;

	logic push, pop;
	mid_item_t mid_in, mid_out;
	fifo_stat_t fstat;

	vnb_front u_front (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready), .item(item),
		.push(push), .mid(mid_in), .full(fstat.full)
	);

	vnb_fifo u_fifo (
		.clk(clk), .arst_n(arst_n),
		.push(push), .push_data(mid_in),
		.pop(pop), .pop_data(mid_out), .stat(fstat)
	);

	vnb_back u_back (
		.clk(clk), .arst_n(arst_n),
		.mid_valid(!fstat.empty), .mid(mid_out), .pop(pop),
		.result_valid(result_valid), .result_ready(result_ready), .result(result)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !fstat.full)
		else $error("Queue written while full.");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !fstat.empty)
		else $error("Queue read while empty.");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.status != ST_OK) |->
		(result.v_x == '0) && (result.n_x == '0) && (result.b_x == '0))
		else $error("Failed basis carries non-zero components.");

endmodule

// File: rtl/vnb_front.sv
module vnb_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  vnb_pkg::in_item_t item,
	output logic              push,
	output vnb_pkg::mid_item_t mid,
	input  logic              full
);
	import vnb_pkg::*;

	logic en;
	logic v_s1, v_s2;
	logic signed [PROD_W-1:0] prod_s1 [0:5];
	logic [2:0][COORD_WIDTH-1:0] vel_s1;
	mid_item_t mid_s2;

	assign en = !v_s2 || !full;
	assign item_ready = en;
	assign push = v_s2 && !full;
	assign mid = mid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= item_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1[0] <= item.pos_y * item.vel_z;
			prod_s1[1] <= item.pos_z * item.vel_y;
			prod_s1[2] <= item.pos_z * item.vel_x;
			prod_s1[3] <= item.pos_x * item.vel_z;
			prod_s1[4] <= item.pos_x * item.vel_y;
			prod_s1[5] <= item.pos_y * item.vel_x;
			vel_s1 <= {item.vel_z, item.vel_y, item.vel_x};
			mid_s2.rxv[0] <= CROSS_W'(prod_s1[0]) - CROSS_W'(prod_s1[1]);
			mid_s2.rxv[1] <= CROSS_W'(prod_s1[2]) - CROSS_W'(prod_s1[3]);
			mid_s2.rxv[2] <= CROSS_W'(prod_s1[4]) - CROSS_W'(prod_s1[5]);
			mid_s2.vel <= vel_s1;
			mid_s2.vzero <= (vel_s1 == '0);
		end
	end

endmodule

// File: rtl/vnb_fifo.sv
module vnb_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  vnb_pkg::mid_item_t  push_data,
	input  logic                pop,
	output vnb_pkg::mid_item_t  pop_data,
	output vnb_pkg::fifo_stat_t stat
);
	import vnb_pkg::*;

	mid_item_t mem_q [0:FIFO_DEPTH-1];
	logic [FIFO_AW-1:0] wp_q, rp_q;
	logic [FIFO_AW:0] cnt_q;

	assign stat.full = (cnt_q == (FIFO_AW+1)'(FIFO_DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign pop_data = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= push_data;
		end
	end

endmodule

// File: rtl/vnb_norm.sv
module vnb_norm (
	input  logic           clk,
	input  logic           en,
	input  vnb_pkg::nvec_t vec,
	output vnb_pkg::uvec_t unit,
	output logic           zero
);
	import vnb_pkg::*;

	typedef struct packed {
		logic [2:0] neg;
		logic zero;
	} side_t;

	side_t sd_q [0:NORM_LAT-1];
	logic [2:0][NORM_W-1:0] mag_q [0:SHIFT_STAGES];
	logic [NORM_W-1:0] orw_q [0:SHIFT_STAGES];
	logic [2:0][NORM_W-1:0] mag_in;
	uvec_t a_w, a_sq_q, a_sum_q;
	logic [BPROD_W-1:0] sq_q [0:2];
	logic [SUM_W-1:0] s_q;
	logic [SQ_REM_W-1:0] rem_q [0:ROOT_W-1];
	logic [ROOT_W-1:0] root_q [0:ROOT_W-1];
	logic [SUM_W-1:0] x_q [0:ROOT_W-1];
	uvec_t ar_q [0:ROOT_W-1];
	logic [2:0][DIV_REM_W-1:0] drem_q [0:UNIT_W-1];
	uvec_t q_q [0:UNIT_W-1];
	logic [ROOT_W-1:0] dr_q [0:UNIT_W-1];
	uvec_t u_q;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag_in[i] = vec[i][NORM_W-1] ? (~vec[i] + 1'b1) : vec[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_q[0] <= mag_in;
			orw_q[0] <= mag_in[0] | mag_in[1] | mag_in[2];
			sd_q[0].neg <= {vec[2][NORM_W-1], vec[1][NORM_W-1], vec[0][NORM_W-1]};
			sd_q[0].zero <= ((mag_in[0] | mag_in[1] | mag_in[2]) == '0);
			for (int k = 1; k < NORM_LAT; k++) begin
				sd_q[k] <= sd_q[k-1];
			end
		end
	end

	for (genvar k = 0; k < SHIFT_STAGES; k++) begin : g_shift
		localparam int SH = 2 ** (SHIFT_STAGES - 1 - k);
		always_ff @(posedge clk) begin
			if (en) begin
				if (orw_q[k][NORM_W-1 -: SH] == '0) begin
					orw_q[k+1] <= orw_q[k] << SH;
					for (int i = 0; i < 3; i++) begin
						mag_q[k+1][i] <= mag_q[k][i] << SH;
					end
				end else begin
					orw_q[k+1] <= orw_q[k];
					mag_q[k+1] <= mag_q[k];
				end
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			a_w[i] = mag_q[SHIFT_STAGES][i][NORM_W-1 -: UNIT_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_q[i] <= a_w[i] * a_w[i];
			end
			a_sq_q <= a_w;
			s_q <= SUM_W'(sq_q[0]) + SUM_W'(sq_q[1]) + SUM_W'(sq_q[2]);
			a_sum_q <= a_sq_q;
		end
	end

	for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
		logic [SQ_REM_W-1:0] rin, tr, trial;
		logic [ROOT_W-1:0] oin;
		logic [SUM_W-1:0] xin;
		uvec_t ain;
		if (j == 0) begin : g_first
			assign rin = '0;
			assign oin = '0;
			assign xin = s_q;
			assign ain = a_sum_q;
		end else begin : g_next
			assign rin = rem_q[j-1];
			assign oin = root_q[j-1];
			assign xin = x_q[j-1];
			assign ain = ar_q[j-1];
		end
		assign tr = {rin[SQ_REM_W-3:0], xin[SUM_W-1 -: 2]};
		assign trial = SQ_REM_W'({oin, 2'b01});
		always_ff @(posedge clk) begin
			if (en) begin
				if (tr >= trial) begin
					rem_q[j] <= tr - trial;
					root_q[j] <= {oin[ROOT_W-2:0], 1'b1};
				end else begin
					rem_q[j] <= tr;
					root_q[j] <= {oin[ROOT_W-2:0], 1'b0};
				end
				x_q[j] <= xin << 2;
				ar_q[j] <= ain;
			end
		end
	end

	for (genvar j = 0; j < UNIT_W; j++) begin : g_div
		logic [2:0][DIV_REM_W-1:0] rin, t;
		uvec_t qin;
		logic [ROOT_W-1:0] rr;
		logic [2:0] ge;
		if (j == 0) begin : g_first
			always_comb begin
				for (int i = 0; i < 3; i++) begin
					rin[i] = DIV_REM_W'(ar_q[ROOT_W-1][i]);
					t[i] = rin[i];
				end
			end
			assign qin = '0;
			assign rr = root_q[ROOT_W-1];
		end else begin : g_next
			always_comb begin
				for (int i = 0; i < 3; i++) begin
					rin[i] = drem_q[j-1][i];
					t[i] = {rin[i][DIV_REM_W-2:0], 1'b0};
				end
			end
			assign qin = q_q[j-1];
			assign rr = dr_q[j-1];
		end
		always_comb begin
			for (int i = 0; i < 3; i++) begin
				ge[i] = (t[i] >= DIV_REM_W'(rr));
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 3; i++) begin
					drem_q[j][i] <= ge[i] ? (t[i] - DIV_REM_W'(rr)) : t[i];
					q_q[j][i] <= {qin[i][UNIT_W-2:0], ge[i]};
				end
				dr_q[j] <= rr;
			end
		end
	end

	always_ff @(posedge clk) begin
		logic [UNIT_W:0] rs;
		logic [UNIT_W-1:0] rh;
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				rs = (UNIT_W+1)'(q_q[UNIT_W-1][i]) + 1'b1;
				rh = rs[UNIT_W:1];
				u_q[i] <= sd_q[NORM_LAT-2].neg[i] ? (~rh + 1'b1) : rh;
			end
		end
	end

	assign unit = u_q;
	assign zero = sd_q[NORM_LAT-1].zero;

endmodule

// File: rtl/vnb_back.sv
module vnb_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               mid_valid,
	input  vnb_pkg::mid_item_t mid,
	output logic               pop,
	output logic               result_valid,
	input  logic               result_ready,
	output vnb_pkg::out_item_t result
);
	import vnb_pkg::*;

	typedef struct packed {
		uvec_t vu;
		uvec_t nu;
		logic vzero;
		logic nzero;
	} vn_t;

	logic en;
	logic vld_q [0:BACK_LAT-1];
	nvec_t vvec, nvec;
	uvec_t vu, nu, bu;
	logic vz_norm, nzero, bzero;
	logic vz_q [0:NORM_LAT-1];
	logic signed [BPROD_W-1:0] bp_q [0:5];
	nvec_t bc_q;
	vn_t dl_q [0:NORM_LAT+1];
	out_item_t res_q;
	status_t st;

	assign en = !vld_q[BACK_LAT-1] || result_ready;
	assign pop = en && mid_valid;
	assign result_valid = vld_q[BACK_LAT-1];
	assign result = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < BACK_LAT; k++) begin
				vld_q[k] <= 1'b0;
			end
		end else if (en) begin
			vld_q[0] <= mid_valid;
			for (int k = 1; k < BACK_LAT; k++) begin
				vld_q[k] <= vld_q[k-1];
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			vvec[i] = {{(NORM_W-COORD_WIDTH){mid.vel[i][COORD_WIDTH-1]}}, mid.vel[i]};
			nvec[i] = {{(NORM_W-CROSS_W){mid.rxv[i][CROSS_W-1]}}, mid.rxv[i]};
		end
	end

	vnb_norm u_vnorm (.clk(clk), .en(en), .vec(vvec), .unit(vu), .zero(vz_norm));
	vnb_norm u_nnorm (.clk(clk), .en(en), .vec(nvec), .unit(nu), .zero(nzero));

	always_ff @(posedge clk) begin
		if (en) begin
			vz_q[0] <= mid.vzero;
			for (int k = 1; k < NORM_LAT; k++) begin
				vz_q[k] <= vz_q[k-1];
			end
			bp_q[0] <= $signed(vu[1]) * $signed(nu[2]);
			bp_q[1] <= $signed(vu[2]) * $signed(nu[1]);
			bp_q[2] <= $signed(vu[2]) * $signed(nu[0]);
			bp_q[3] <= $signed(vu[0]) * $signed(nu[2]);
			bp_q[4] <= $signed(vu[0]) * $signed(nu[1]);
			bp_q[5] <= $signed(vu[1]) * $signed(nu[0]);
			bc_q[0] <= NORM_W'(BCROSS_W'(bp_q[0]) - BCROSS_W'(bp_q[1]));
			bc_q[1] <= NORM_W'(BCROSS_W'(bp_q[2]) - BCROSS_W'(bp_q[3]));
			bc_q[2] <= NORM_W'(BCROSS_W'(bp_q[4]) - BCROSS_W'(bp_q[5]));
			dl_q[0] <= '{vu: vu, nu: nu, vzero: vz_q[NORM_LAT-1] || vz_norm, nzero: nzero};
			for (int k = 1; k < NORM_LAT + 2; k++) begin
				dl_q[k] <= dl_q[k-1];
			end
		end
	end

	vnb_norm u_bnorm (.clk(clk), .en(en), .vec(bc_q), .unit(bu), .zero(bzero));

	always_comb begin
		if (dl_q[NORM_LAT+1].vzero) begin
			st = ST_ZERO_VEL;
		end else if (dl_q[NORM_LAT+1].nzero) begin
			st = ST_ZERO_NORMAL;
		end else if (bzero) begin
			st = ST_ZERO_BINORMAL;
		end else begin
			st = ST_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (st == ST_OK) begin
				res_q.v_x <= dl_q[NORM_LAT+1].vu[0];
				res_q.v_y <= dl_q[NORM_LAT+1].vu[1];
				res_q.v_z <= dl_q[NORM_LAT+1].vu[2];
				res_q.n_x <= dl_q[NORM_LAT+1].nu[0];
				res_q.n_y <= dl_q[NORM_LAT+1].nu[1];
				res_q.n_z <= dl_q[NORM_LAT+1].nu[2];
				res_q.b_x <= bu[0];
				res_q.b_y <= bu[1];
				res_q.b_z <= bu[2];
			end else begin
				res_q.v_x <= '0;
				res_q.v_y <= '0;
				res_q.v_z <= '0;
				res_q.n_x <= '0;
				res_q.n_y <= '0;
				res_q.n_z <= '0;
				res_q.b_x <= '0;
				res_q.b_y <= '0;
				res_q.b_z <= '0;
			end
			res_q.status <= st;
		end
	end

endmodule
